FILE: sv/zvc_pkg.sv
// package for the zigzag varint codec: types, constants and zigzag functions
`timescale 1ns / 1ps

package zvc_pkg;

	localparam int DATA_W         = 64;
	localparam int NARROW_W       = 32;
	localparam int BYTE_W         = 8;
	localparam int GROUP_W        = 7;
	localparam int COUNT_W        = 4;
	localparam int SHIFT_W        = 7;
	localparam int QUEUE_DEPTH_D  = 2;

	localparam logic [GROUP_W-1:0] GROUP_MASK   = 7'h7F;
	localparam logic [BYTE_W-1:0]  MORE_FLAG    = 8'h80;
	localparam logic [COUNT_W:0]   NARROW_LIMIT = 5'd5;
	localparam logic [COUNT_W:0]   WIDE_LIMIT   = 5'd10;
	localparam logic [COUNT_W-1:0] LAST_GROUP   = 4'd9;

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_VALUE = 1'b1
	} kind_t;

	// one queue word: encode carries the value (zigzag-mapped when signed), decode the raw byte
	typedef struct packed {
		cmd_t              cmd;
		logic              sgn;
		logic              wide;
		logic [DATA_W-1:0] data;
	} entry_t;

	function automatic logic [DATA_W-1:0] zz_map(input logic [DATA_W-1:0] v, input logic wide);
		logic [NARROW_W-1:0] n;
		begin
			n = v[NARROW_W-1:0];
			if (wide) begin
				zz_map = {v[DATA_W-2:0], 1'b0} ^ {DATA_W{v[DATA_W-1]}};
			end else begin
				zz_map = {{(DATA_W-NARROW_W){1'b0}},
					{n[NARROW_W-2:0], 1'b0} ^ {NARROW_W{n[NARROW_W-1]}}};
			end
		end
	endfunction

	function automatic logic [DATA_W-1:0] zz_unmap(input logic [DATA_W-1:0] v, input logic wide);
		logic [NARROW_W-1:0] n;
		begin
			n = v[NARROW_W-1:0];
			if (wide) begin
				zz_unmap = {1'b0, v[DATA_W-1:1]} ^ {DATA_W{v[0]}};
			end else begin
				zz_unmap = {{(DATA_W-NARROW_W){1'b0}},
					{1'b0, n[NARROW_W-1:1]} ^ {NARROW_W{n[0]}}};
			end
		end
	endfunction

endpackage

FILE: sv/zvc_front.sv
// front end: accepts input words, classifies them and applies the zigzag map to signed encode values
`timescale 1ns / 1ps

module zvc_front
	import zvc_pkg::*;
(
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic              signed_mode,
	input  logic              wide_mode,
	input  logic [DATA_W-1:0] value_in,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              push,
	output entry_t            push_entry,
	input  logic              queue_full
);

	logic [DATA_W-1:0] raw_value;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		raw_value = wide_mode ? value_in : {{(DATA_W-NARROW_W){1'b0}}, value_in[NARROW_W-1:0]};
		push_entry.cmd  = cmd_t'(command);
		push_entry.sgn  = signed_mode;
		push_entry.wide = wide_mode;
		unique case (cmd_t'(command))
			CMD_ENCODE: begin
				push_entry.data = signed_mode ? zz_map(raw_value, wide_mode) : raw_value;
			end
			CMD_DECODE: begin
				push_entry.data = {{(DATA_W-BYTE_W){1'b0}}, data_byte};
			end
			default: begin
				push_entry.data = '0;
			end
		endcase
	end

endmodule

FILE: sv/zvc_queue.sv
// short register queue between the front and back ends
`timescale 1ns / 1ps

module zvc_queue
	import zvc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_D
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t            mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/zvc_back.sv
// back end: emits encoded bytes one per cycle while the output is not stalled, and assembles decoded values
`timescale 1ns / 1ps

module zvc_back
	import zvc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  entry_t            head_entry,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [BYTE_W-1:0] byte_out,
	output logic [DATA_W-1:0] value_out,
	output logic              last
);

	logic               out_valid_q;
	kind_t              kind_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [DATA_W-1:0]  value_q;
	logic               last_q;

	logic               enc_busy_q;
	logic [DATA_W-1:0]  enc_v_q;
	logic [COUNT_W-1:0] enc_n_q;

	logic [DATA_W-1:0]  acc_q;
	logic [COUNT_W-1:0] gc_q;

	logic               can_load;
	logic               enc_step;
	logic               dec_step;
	logic [DATA_W-1:0]  cur_v;
	logic [COUNT_W-1:0] cur_n;
	logic               enc_more;
	logic [SHIFT_W-1:0] shift;
	logic [DATA_W-1:0]  acc_new;
	logic [COUNT_W:0]   limit;
	logic               dec_more;
	logic [DATA_W-1:0]  dec_raw;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign byte_out  = byte_q;
	assign value_out = value_q;
	assign last      = last_q;

	always_comb begin
		can_load = !out_valid_q || !out_stall;
		pop      = !enc_busy_q && head_valid && can_load;
		enc_step = (enc_busy_q && can_load) || (pop && head_entry.cmd == CMD_ENCODE);
		dec_step = pop && head_entry.cmd == CMD_DECODE;

		cur_v    = enc_busy_q ? enc_v_q : head_entry.data;
		cur_n    = enc_busy_q ? enc_n_q : '0;
		enc_more = (cur_v[DATA_W-1:GROUP_W] != '0) && (cur_n < LAST_GROUP);

		shift    = SHIFT_W'(gc_q) * SHIFT_W'(GROUP_W);
		acc_new  = acc_q;
		if (shift < SHIFT_W'(DATA_W)) begin
			acc_new = acc_q | ({{(DATA_W-GROUP_W){1'b0}},
				head_entry.data[GROUP_W-1:0] & GROUP_MASK} << shift[5:0]);
		end
		limit    = head_entry.wide ? WIDE_LIMIT : NARROW_LIMIT;
		dec_more = ((head_entry.data[BYTE_W-1:0] & MORE_FLAG) != '0)
			&& ({1'b0, gc_q} + 1'b1 < limit);
		dec_raw  = head_entry.wide ? acc_new
			: {{(DATA_W-NARROW_W){1'b0}}, acc_new[NARROW_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			enc_busy_q  <= 1'b0;
			enc_n_q     <= '0;
			acc_q       <= '0;
			gc_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (enc_step) begin
				out_valid_q <= 1'b1;
				enc_busy_q  <= enc_more;
				enc_n_q     <= cur_n + 1'b1;
			end else if (dec_step) begin
				if (dec_more) begin
					acc_q <= acc_new;
					gc_q  <= gc_q + 1'b1;
				end else begin
					out_valid_q <= 1'b1;
					acc_q       <= '0;
					gc_q        <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_step) begin
			enc_v_q <= cur_v >> GROUP_W;
			kind_q  <= KIND_BYTE;
			byte_q  <= enc_more ? ({1'b0, cur_v[GROUP_W-1:0]} | MORE_FLAG) : cur_v[BYTE_W-1:0];
			value_q <= '0;
			last_q  <= !enc_more;
		end else if (dec_step && !dec_more) begin
			kind_q  <= KIND_VALUE;
			byte_q  <= '0;
			value_q <= head_entry.sgn ? zz_unmap(dec_raw, head_entry.wide) : dec_raw;
			last_q  <= 1'b1;
		end
	end

endmodule

FILE: sv/zigzag_varint_codec_top.sv
// top level of the zigzag varint codec
`timescale 1ns / 1ps

// usage:
// input channel (in_valid / in_stall) takes one word per accepted edge: command
// selects encode of value_in or decode of data_byte, signed_mode applies the
// zigzag map, wide_mode picks 64-bit over 32-bit values.
// output channel (out_valid / out_stall) gives result words: kind 0 is an
// encoded byte in byte_out, kind 1 a decoded value in value_out; last marks
// the final result of an input word.
// path: with the back end idle, an accepted input word is written into the
// queue register, and its result then into the output register.
// flow: the back end emits one encoded byte per cycle while out_stall is low,
// and an encode word gives 1 to 10 output bytes; no new word is taken until
// its last byte is out. the queue between front and back end keeps accepting
// input words while the back end is still busy, until it is full.
// reset clears the queue, the decode accumulator and byte count, and the
// output valid. when the receiver stalls, the output word holds, the back end
// stops, and once the queue is full in_stall rises.
module zigzag_varint_codec_top
	import zvc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic              signed_mode,
	input  logic              wide_mode,
	input  logic [DATA_W-1:0] value_in,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [BYTE_W-1:0] byte_out,
	output logic [DATA_W-1:0] value_out,
	output logic              last
);

	logic   push;
	entry_t push_entry;
	logic   queue_full;
	logic   pop;
	logic   head_valid;
	entry_t head_entry;

	zvc_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.signed_mode (signed_mode),
		.wide_mode   (wide_mode),
		.value_in    (value_in),
		.data_byte   (data_byte),
		.push        (push),
		.push_entry  (push_entry),
		.queue_full  (queue_full)
	);

	zvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	zvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.byte_out   (byte_out),
		.value_out  (value_out),
		.last       (last)
	);

endmodule
